// ===== rtl/core/fsa_pkg.sv =====
// shared types, constants and helper functions for the fixed slot allocator
package fsa_pkg;

   localparam int DEF_MAX_PAGES = 8;
   localparam int PAGE_SHIFT    = 12;
   localparam int PAGE_NO_W     = 64 - PAGE_SHIFT;
   localparam int WORD_BITS     = 64;
   localparam int WORD_SEL_W    = 3;
   localparam int BIT_SEL_W     = 6;
   localparam int SIZE_W        = 12;
   localparam int COUNT_W       = 9;
   localparam int MIN_SIZE      = 8;
   localparam int USABLE_BYTES  = 4096 - 8;
   localparam int CSR_INDEX_W   = 8;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ITEM_SIZE      = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOTS_PER_PAGE = CSR_INDEX_W'(1);

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_OOM,
      STAT_BAD_ADDR,
      STAT_DOUBLE_FREE
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CNT,
      ST_OFS,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_BIT_RD,
      ST_BIT_CHK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_MUL,
      ST_GROW,
      ST_FILL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              start;
      logic [SIZE_W-1:0] dividend;
      logic [SIZE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] quot;
      logic [SIZE_W-1:0] rem;
   } div_rsp_type;

   // slot size with the one-pointer minimum applied
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
      eff_size = (size < SIZE_W'(MIN_SIZE)) ? SIZE_W'(MIN_SIZE) : size;
   endfunction

   // bits of word w whose slot index lies below count
   function automatic logic [WORD_BITS-1:0] avail_mask(
      input logic [WORD_SEL_W-1:0] w,
      input logic [COUNT_W-1:0]    count
   );
      logic [WORD_BITS-1:0] m;
      m = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         m[b] = ({w, BIT_SEL_W'(b)} < count);
      end
      avail_mask = m;
   endfunction

   // lowest set bit position of a word
   function automatic logic [BIT_SEL_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
      logic [BIT_SEL_W-1:0] pos;
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (v[b]) begin
            pos = BIT_SEL_W'(b);
         end
      end
      lowest_bit = pos;
   endfunction

endpackage

// ===== rtl/core/fsa_ram.sv =====
// generic single write port ram with registered read
module fsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fsa_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module fsa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  fsa_pkg::div_req_type req,
   output fsa_pkg::div_rsp_type rsp
);
   import fsa_pkg::*;

   localparam int CNT_W = $clog2(SIZE_W + 1);

   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] quo_ff, quo_in;
   logic [SIZE_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [SIZE_W:0]   trial;

   // one shift and subtract step
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[SIZE_W-1]};
      if (req.start) begin
         rem_in = '0;
         quo_in = req.dividend;
         dvs_in = req.divisor;
         cnt_in = CNT_W'(SIZE_W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = SIZE_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[SIZE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[SIZE_W-1:0];
            quo_in = {quo_ff[SIZE_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

// ===== rtl/core/fixed_slot_allocator_unit.sv =====
// fixed slot allocator top level: sequencer around page base and free bitmap rams
//
//  channel | ports                                     | handshake
//  --------+-------------------------------------------+--------------------------
//  request | req_op req_block_addr req_frame_*         | start & !busy
//  result  | rsp_slot_addr rsp_status                  | rsp_strobe, one cycle
//  config  | csr_index csr_wdata                       | csr_valid & csr_ready
//
// one word at a time; every item first runs a 12 step division for the usable count,
// which holds busy. busy time, result strobe included, grows for free with each adopted
// page searched, and for alloc with each bitmap word scanned (8 words per page), with
// a page fill added when a new page is adopted.
// the bitmap read is registered, so the scan alternates a read state and a check state.
// reset is synchronous and clears the page count; the rams need no clearing.
// results cannot be stalled; busy stays high until the result strobe has gone out.
module fixed_slot_allocator_unit #(
   parameter int MAX_PAGES = fsa_pkg::DEF_MAX_PAGES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic [63:0]                        req_block_addr,
   input  logic [63:0]                        req_frame_addr,
   input  logic                               req_frame_valid,
   output logic                               rsp_strobe,
   output logic [63:0]                        rsp_slot_addr,
   output logic [1:0]                         rsp_status,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fsa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fsa_pkg::SIZE_W-1:0]         csr_wdata
);
   import fsa_pkg::*;

   localparam int PAGE_AW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int PAGES_W  = $clog2(MAX_PAGES + 1);
   localparam int WORD_AW  = PAGE_AW + WORD_SEL_W;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]     item_size_ff;
   logic [COUNT_W-1:0]    spp_ff;
   logic [PAGES_W-1:0]    pages_ff, pages_in;
   logic                  op_ff, op_in;
   logic [63:0]           block_ff, block_in;
   logic [PAGE_NO_W-1:0]  frame_ff, frame_in;
   logic                  fvalid_ff, fvalid_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    qidx_ff, qidx_in;
   logic [PAGE_AW-1:0]    page_ff, page_in;
   logic [WORD_SEL_W-1:0] word_ff, word_in;
   logic                  dup_ff, dup_in;
   logic [COUNT_W-1:0]    idx_ff, idx_in;
   logic [PAGE_NO_W-1:0]  base_ff, base_in;
   logic [63:0]           addr_ff, addr_in;
   status_type            status_ff, status_in;

   logic [SIZE_W-1:0]     size_eff;
   div_req_type           dreq;
   div_rsp_type           drsp;
   logic [COUNT_W-1:0]    div_count;

   logic                  base_we;
   logic [PAGE_AW-1:0]    base_waddr;
   logic [PAGE_NO_W-1:0]  base_rd;
   logic                  bits_we;
   logic [WORD_BITS-1:0]  bits_wdata;
   logic [WORD_BITS-1:0]  bits_rd;
   logic [WORD_BITS-1:0]  masked;
   logic                  tail_page;
   logic                  grow_bad;

   assign size_eff  = eff_size(item_size_ff);
   assign masked    = bits_rd & avail_mask(word_ff, count_ff);
   assign tail_page = ((PAGES_W'(page_ff) + PAGES_W'(1)) == pages_ff);
   assign div_count = (drsp.quot > SIZE_W'(spp_ff)) ? spp_ff : drsp.quot[COUNT_W-1:0];
   assign grow_bad  = (count_ff == '0) || !fvalid_ff || (frame_ff == '0) ||
                      (pages_ff >= PAGES_W'(MAX_PAGES)) || dup_ff;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         item_size_ff <= SIZE_W'(MIN_SIZE);
         spp_ff       <= COUNT_W'(511);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ITEM_SIZE:      item_size_ff <= csr_wdata;
            CSR_SLOTS_PER_PAGE: spp_ff       <= csr_wdata[COUNT_W-1:0];
            default:            ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (start) state_in = ST_CNT;
         ST_CNT: begin
            if (drsp.done) begin
               if (op_ff == OP_FREE) begin
                  state_in = (block_ff == '0) ? ST_RESP : ST_OFS;
               end else begin
                  state_in = (pages_ff == '0) ? ST_GROW : ST_SCAN_RD;
               end
            end
         end
         ST_OFS: begin
            if (drsp.done) begin
               if ((drsp.rem != '0) || (drsp.quot >= SIZE_W'(count_ff)) || (pages_ff == '0)) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_FIND_RD;
               end
            end
         end
         ST_FIND_RD:  state_in = ST_FIND_CHK;
         ST_FIND_CHK: begin
            if (base_rd == block_ff[63:PAGE_SHIFT]) state_in = ST_BIT_RD;
            else if (tail_page)                      state_in = ST_RESP;
            else                                     state_in = ST_FIND_RD;
         end
         ST_BIT_RD:   state_in = ST_BIT_CHK;
         ST_BIT_CHK:  state_in = ST_RESP;
         ST_SCAN_RD:  state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (masked != '0)                                    state_in = ST_MUL;
            else if (tail_page && (word_ff == '1))               state_in = ST_GROW;
            else                                                 state_in = ST_SCAN_RD;
         end
         ST_MUL:      state_in = ST_RESP;
         ST_GROW:     state_in = grow_bad ? ST_RESP : ST_FILL;
         ST_FILL:     if (word_ff == '1) state_in = ST_RESP;
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and ram controls
   always_comb begin
      op_in      = op_ff;
      block_in   = block_ff;
      frame_in   = frame_ff;
      fvalid_in  = fvalid_ff;
      count_in   = count_ff;
      qidx_in    = qidx_ff;
      page_in    = page_ff;
      word_in    = word_ff;
      dup_in     = dup_ff;
      idx_in     = idx_ff;
      base_in    = base_ff;
      addr_in    = addr_ff;
      status_in  = status_ff;
      pages_in   = pages_ff;
      dreq       = '0;
      base_we    = 1'b0;
      base_waddr = pages_ff[PAGE_AW-1:0];
      bits_we    = 1'b0;
      bits_wdata = bits_rd;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in         = req_op;
               block_in      = req_block_addr;
               frame_in      = req_frame_addr[63:PAGE_SHIFT];
               fvalid_in     = req_frame_valid;
               dup_in        = 1'b0;
               addr_in       = '0;
               status_in     = STAT_OK;
               dreq.start    = 1'b1;
               dreq.dividend = SIZE_W'(USABLE_BYTES);
               dreq.divisor  = size_eff;
            end
         end
         ST_CNT: begin
            if (drsp.done) begin
               count_in = div_count;
               page_in  = '0;
               word_in  = '0;
               if (op_ff == OP_FREE) begin
                  if (block_ff == '0) begin
                     status_in = STAT_BAD_ADDR;
                  end else begin
                     dreq.start    = 1'b1;
                     dreq.dividend = block_ff[PAGE_SHIFT-1:0];
                     dreq.divisor  = size_eff;
                  end
               end
            end
         end
         ST_OFS: begin
            if (drsp.done) begin
               qidx_in = drsp.quot[COUNT_W-1:0];
               if ((drsp.rem != '0) || (drsp.quot >= SIZE_W'(count_ff)) || (pages_ff == '0)) begin
                  status_in = STAT_BAD_ADDR;
               end
            end
         end
         ST_FIND_CHK: begin
            if (base_rd == block_ff[63:PAGE_SHIFT]) begin
               word_in = qidx_ff[COUNT_W-1:BIT_SEL_W];
            end else if (tail_page) begin
               status_in = STAT_BAD_ADDR;
            end else begin
               page_in = page_ff + PAGE_AW'(1);
            end
         end
         ST_BIT_CHK: begin
            if (bits_rd[qidx_ff[BIT_SEL_W-1:0]]) begin
               status_in = STAT_DOUBLE_FREE;
            end else begin
               bits_we = 1'b1;
               bits_wdata = bits_rd | (WORD_BITS'(1) << qidx_ff[BIT_SEL_W-1:0]);
            end
         end
         ST_SCAN_CHK: begin
            if (base_rd == frame_ff) dup_in = 1'b1;
            if (masked != '0) begin
               idx_in     = {word_ff, lowest_bit(masked)};
               base_in    = base_rd;
               bits_we    = 1'b1;
               bits_wdata = bits_rd & ~(WORD_BITS'(1) << lowest_bit(masked));
            end else begin
               word_in = word_ff + WORD_SEL_W'(1);
               if (word_ff == '1) page_in = page_ff + PAGE_AW'(1);
            end
         end
         ST_MUL: begin
            addr_in = {base_ff, PAGE_SHIFT'(0)} + 64'(idx_ff * size_eff);
         end
         ST_GROW: begin
            if (grow_bad) begin
               status_in = STAT_OOM;
            end else begin
               base_we = 1'b1;
               page_in = pages_ff[PAGE_AW-1:0];
               word_in = '0;
            end
         end
         ST_FILL: begin
            bits_we    = 1'b1;
            bits_wdata = avail_mask(word_ff, count_ff) &
                         ~((word_ff == '0) ? WORD_BITS'(1) : WORD_BITS'(0));
            word_in    = word_ff + WORD_SEL_W'(1);
            if (word_ff == '1) begin
               pages_in = pages_ff + PAGES_W'(1);
               addr_in  = {frame_ff, PAGE_SHIFT'(0)};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pages_ff <= '0;
      end else begin
         state_ff <= state_in;
         pages_ff <= pages_in;
      end
      op_ff     <= op_in;
      block_ff  <= block_in;
      frame_ff  <= frame_in;
      fvalid_ff <= fvalid_in;
      count_ff  <= count_in;
      qidx_ff   <= qidx_in;
      page_ff   <= page_in;
      word_ff   <= word_in;
      dup_ff    <= dup_in;
      idx_ff    <= idx_in;
      base_ff   <= base_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
   end

   // shared divider for usable count and slot offset
   fsa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   // page base numbers in adoption order
   fsa_ram #(
      .WIDTH (PAGE_NO_W),
      .DEPTH (1 << PAGE_AW),
      .AW    (PAGE_AW)
   ) u_base_ram (
      .clock   (clock),
      .wr_en   (base_we),
      .wr_addr (base_waddr),
      .wr_data (frame_ff),
      .rd_addr (page_ff),
      .rd_data (base_rd)
   );

   // free bitmap, eight words per page
   fsa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (1 << WORD_AW),
      .AW    (WORD_AW)
   ) u_bits_ram (
      .clock   (clock),
      .wr_en   (bits_we),
      .wr_addr ({page_ff, word_ff}),
      .wr_data (bits_wdata),
      .rd_addr ({page_ff, word_ff}),
      .rd_data (bits_rd)
   );

   // outputs
   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = (state_ff == ST_RESP);
   assign rsp_slot_addr = (status_ff == STAT_OK) ? addr_ff : '0;
   assign rsp_status    = status_ff;

`ifndef SYNTH
   a_pages_bound: assert property (@(posedge clock) disable iff (reset)
      pages_ff <= PAGES_W'(MAX_PAGES))
      else $error("page count beyond table size");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("more than one result for an item");

   a_free_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (op_ff == OP_FREE)) |-> (rsp_slot_addr == '0))
      else $error("free returned a nonzero address");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");
`endif

endmodule

// ===== verif/tb_fixed_slot_allocator_unit.sv =====
// self-checking testbench for the fixed slot allocator: queued stimulus, predictor, checker
module tb_fixed_slot_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import fsa_pkg::*;

   localparam int NUM_PAGES   = DEF_MAX_PAGES;
   localparam int STALL_LIMIT = 20000;

   typedef enum logic { KIND_FIXED, KIND_FREE_LIVE } word_kind_type;

   typedef struct {
      word_kind_type kind;
      logic          op;
      logic [63:0]   block_addr;
      logic [63:0]   frame_addr;
      logic          frame_valid;
      logic          calm;
   } alloc_word_type;

   typedef struct {
      logic [63:0] slot_addr;
      status_type  status;
   } alloc_result_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_op;
   logic [63:0]            req_block_addr;
   logic [63:0]            req_frame_addr;
   logic                   req_frame_valid;
   logic                   rsp_strobe;
   logic [63:0]            rsp_slot_addr;
   logic [1:0]             rsp_status;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [SIZE_W-1:0]      csr_wdata;

   fixed_slot_allocator_unit dut (.*);

   // shadow allocator state
   logic [SIZE_W-1:0]    shadow_size;
   logic [COUNT_W-1:0]   shadow_slots;
   logic [PAGE_NO_W-1:0] shadow_base [NUM_PAGES];
   int                   shadow_pages;
   logic [511:0]         shadow_free [NUM_PAGES];

   alloc_word_type   pending_words[$];
   alloc_result_type expected_results[$];
   logic [63:0]      live_slots[$];
   int               fail_count;
   int               words_sent;
   int               results_seen;
   int               status_seen [4];
   int               quiet_cycles;

   // clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [SIZE_W-1:0] slot_bytes();
      return (shadow_size < SIZE_W'(MIN_SIZE)) ? SIZE_W'(MIN_SIZE) : shadow_size;
   endfunction

   function automatic int usable_slots();
      int fit;
      fit = USABLE_BYTES / int'(slot_bytes());
      return (int'(shadow_slots) < fit) ? int'(shadow_slots) : fit;
   endfunction

   // compute the expected result of one accepted word and update the shadow state
   function automatic alloc_result_type predict_allocation(logic op, logic [63:0] blk,
                                                           logic [63:0] frm, logic fv);
      alloc_result_type r;
      int               cnt;
      int               pg;
      logic [PAGE_NO_W-1:0] pn;
      logic [11:0]      offs;
      logic [SIZE_W-1:0] sz;
      int               idx;
      cnt = usable_slots();
      sz = slot_bytes();
      r.slot_addr = '0;
      r.status = STAT_OK;
      if (op == OP_ALLOC) begin
         for (int p = 0; p < shadow_pages; p++) begin
            for (int i = 0; i < cnt; i++) begin
               if (shadow_free[p][i]) begin
                  shadow_free[p][i] = 1'b0;
                  r.slot_addr = {shadow_base[p], 12'h000} + 64'(i) * 64'(sz);
                  return r;
               end
            end
         end
         pn = frm[63:PAGE_SHIFT];
         if (cnt == 0 || !fv || pn == '0 || shadow_pages >= NUM_PAGES) begin
            r.status = STAT_OOM;
            return r;
         end
         for (int p = 0; p < shadow_pages; p++) begin
            if (shadow_base[p] == pn) begin
               r.status = STAT_OOM;
               return r;
            end
         end
         shadow_base[shadow_pages] = pn;
         shadow_free[shadow_pages] = '0;
         for (int i = 1; i < cnt; i++) shadow_free[shadow_pages][i] = 1'b1;
         shadow_pages++;
         r.slot_addr = {pn, 12'h000};
         return r;
      end
      // free path
      r.status = STAT_BAD_ADDR;
      if (blk == '0) return r;
      pg = -1;
      for (int p = 0; p < shadow_pages; p++) begin
         if (pg < 0 && shadow_base[p] == blk[63:PAGE_SHIFT]) pg = p;
      end
      if (pg < 0) return r;
      offs = blk[11:0];
      if (offs % sz != 0) return r;
      idx = int'(offs / sz);
      if (idx >= cnt) return r;
      if (shadow_free[pg][idx]) begin
         r.status = STAT_DOUBLE_FREE;
         return r;
      end
      shadow_free[pg][idx] = 1'b1;
      r.status = STAT_OK;
      return r;
   endfunction

   // driver: predicts each accepted word, then presents the next one
   always @(posedge clock) begin
      alloc_word_type   w;
      alloc_result_type r;
      int               k;
      if (reset) begin
         start           <= 1'b0;
         req_op          <= OP_ALLOC;
         req_block_addr  <= '0;
         req_frame_addr  <= '0;
         req_frame_valid <= 1'b0;
      end else begin
         if (start && !busy) begin
            r = predict_allocation(req_op, req_block_addr, req_frame_addr, req_frame_valid);
            expected_results.push_back(r);
            if (req_op == OP_ALLOC && r.status == STAT_OK) live_slots.push_back(r.slot_addr);
            words_sent++;
         end
         if (!start || !busy) begin
            if (pending_words.size() > 0 &&
                (pending_words[0].calm || $urandom_range(99) >= 29)) begin
               w = pending_words.pop_front();
               if (w.kind == KIND_FREE_LIVE && live_slots.size() > 0) begin
                  k = $urandom_range(live_slots.size() - 1);
                  w.block_addr = live_slots[k];
                  // sometimes keep the slot listed so it gets freed twice
                  if ($urandom_range(3) != 0) live_slots.delete(k);
               end
               start           <= 1'b1;
               req_op          <= w.op;
               req_block_addr  <= w.block_addr;
               req_frame_addr  <= w.frame_addr;
               req_frame_valid <= w.frame_valid;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest expectation
   always @(posedge clock) begin
      alloc_result_type e;
      if (!reset && rsp_strobe) begin
         results_seen++;
         status_seen[rsp_status]++;
         if (expected_results.size() == 0) begin
            $error("unexpected result word: slot_addr %h status %0d", rsp_slot_addr, rsp_status);
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_slot_addr !== e.slot_addr) begin
               $error("slot_addr expected %h actual %h", e.slot_addr, rsp_slot_addr);
               fail_count++;
            end
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[fixed_slot_allocator_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [SIZE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ITEM_SIZE) shadow_size = value;
      else if (idx == CSR_SLOTS_PER_PAGE) shadow_slots = value[COUNT_W-1:0];
      @(posedge clock);
   endtask

   task automatic push_word(logic op, logic [63:0] blk, logic [63:0] frm, logic fv,
                            logic calm);
      alloc_word_type w;
      w.kind = KIND_FIXED;
      w.op = op;
      w.block_addr = blk;
      w.frame_addr = frm;
      w.frame_valid = fv;
      w.calm = calm;
      pending_words.push_back(w);
   endtask

   task automatic push_live_free(logic calm);
      alloc_word_type w;
      w.kind = KIND_FREE_LIVE;
      w.op = OP_FREE;
      w.block_addr = {$urandom, $urandom};
      w.frame_addr = '0;
      w.frame_valid = 1'b0;
      w.calm = calm;
      pending_words.push_back(w);
   endtask

   // wait until every word is answered and the block has settled
   task automatic drain();
      wait (pending_words.size() == 0 && !start && expected_results.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_frame();
      int sel;
      sel = $urandom_range(99);
      if (sel < 60) return {40'h0, 12'($urandom_range(1, 12)), 12'($urandom)};
      if (sel < 85) return {$urandom, $urandom};
      return 64'($urandom_range(4095));
   endfunction

   // random words: mostly allocations and frees of live slots, some noise
   task automatic random_phase(int n);
      int          sel;
      logic        calm;
      logic [63:0] a;
      for (int i = 0; i < n; i++) begin
         calm = (i >= n / 3 && i < n / 3 + 40);
         sel = $urandom_range(99);
         if (sel < 48) begin
            push_word(OP_ALLOC, {$urandom, $urandom}, pick_frame(),
                      ($urandom_range(9) != 0), calm);
         end else if (sel < 85) begin
            push_live_free(calm);
         end else if (sel < 92) begin
            push_word(OP_FREE, {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom),
                      calm);
         end else begin
            // near-miss addresses inside adopted-looking pages
            a = {40'h0, 12'($urandom_range(1, 12)), 12'($urandom)};
            push_word(OP_FREE, a, {$urandom, $urandom}, 1'($urandom), calm);
         end
      end
      drain();
   endtask

   initial begin
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      fail_count      = 0;
      words_sent      = 0;
      results_seen    = 0;
      quiet_cycles    = 0;
      shadow_size     = 12'd8;
      shadow_slots    = 9'd511;
      shadow_pages    = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at reset settings
      push_word(OP_FREE, 64'h0, 64'h0, 1'b0, 1'b1);
      push_word(OP_FREE, 64'h0000_0000_0000_5000, 64'h0, 1'b0, 1'b1);
      push_word(OP_ALLOC, 64'h0, 64'h0000_0000_0000_3000, 1'b0, 1'b1);
      push_word(OP_ALLOC, 64'h0, 64'h0000_0000_0000_0ABC, 1'b1, 1'b1);
      push_word(OP_ALLOC, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
      push_word(OP_ALLOC, 64'h0, 64'h0000_0000_0000_3123, 1'b1, 1'b1);
      push_word(OP_ALLOC, 64'h0, 64'h0000_0000_0000_3000, 1'b1, 1'b1);
      push_word(OP_FREE, 64'hFFFF_FFFF_FFFF_F000, 64'h0, 1'b0, 1'b1);
      push_word(OP_FREE, 64'hFFFF_FFFF_FFFF_F000, 64'h0, 1'b0, 1'b1);
      push_word(OP_FREE, 64'h0000_0000_0000_3003, 64'h0, 1'b0, 1'b1);
      push_word(OP_FREE, 64'h0000_0000_0000_3FF8, 64'h0, 1'b0, 1'b1);
      push_word(OP_FREE, 64'h0000_0000_0000_3FF0, 64'h0, 1'b0, 1'b1);
      push_word(OP_FREE, 64'h0000_0000_0000_3008, 64'h0, 1'b0, 1'b1);
      push_word(OP_ALLOC, 64'h0, 64'h0, 1'b1, 1'b1);
      drain();
      // zero usable slots, undersized slot, unknown register index
      write_csr(CSR_ITEM_SIZE, 12'd4095);
      write_csr(CSR_SLOTS_PER_PAGE, 12'd3);
      write_csr(CSR_INDEX_W'(5), 12'hFFF);
      push_word(OP_ALLOC, 64'h0, 64'h0000_0000_0000_7000, 1'b1, 1'b1);
      push_word(OP_FREE, 64'h0000_0000_0000_3000, 64'h0, 1'b0, 1'b1);
      drain();
      write_csr(CSR_ITEM_SIZE, 12'd0);
      write_csr(CSR_SLOTS_PER_PAGE, 12'd0);
      push_word(OP_ALLOC, 64'h0, 64'h0000_0000_0000_8000, 1'b1, 1'b1);
      drain();

      // random phases over several settings, extremes included
      write_csr(CSR_ITEM_SIZE, 12'd8);
      write_csr(CSR_SLOTS_PER_PAGE, 12'd511);
      random_phase(240);
      write_csr(CSR_ITEM_SIZE, 12'd24);
      write_csr(CSR_SLOTS_PER_PAGE, 12'd7);
      random_phase(240);
      write_csr(CSR_ITEM_SIZE, 12'd3);
      write_csr(CSR_SLOTS_PER_PAGE, 12'd4);
      random_phase(240);
      write_csr(CSR_ITEM_SIZE, 12'd4088);
      write_csr(CSR_SLOTS_PER_PAGE, 12'd511);
      random_phase(200);
      write_csr(CSR_ITEM_SIZE, 12'd4095);
      write_csr(CSR_SLOTS_PER_PAGE, 12'd2);
      random_phase(40);
      write_csr(CSR_ITEM_SIZE, 12'd12);
      write_csr(CSR_SLOTS_PER_PAGE, 12'd300);
      random_phase(240);
      write_csr(CSR_ITEM_SIZE, 12'd8);
      write_csr(CSR_SLOTS_PER_PAGE, 12'd1);
      random_phase(230);
      repeat (200) @(posedge clock);

      if (expected_results.size() != 0) begin
         $error("%0d result words never arrived", expected_results.size());
         fail_count++;
      end
      $display("run covered %0d request words and %0d result words over %0d pages",
               words_sent, results_seen, shadow_pages);
      $display("status counts: ok %0d, oom %0d, bad address %0d, double free %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (fail_count == 0) begin
         $display("[fixed_slot_allocator_unit] OK");
      end else begin
         $display("[fixed_slot_allocator_unit] ERROR");
      end
      $finish;
   end

endmodule
